// ===== rtl/core/gmpc_pkg.sv =====
// Shared constants and types for the grid minimum path cost block.
package gmpc_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_LIMIT  = 4096;
  localparam int ROW_W      = $clog2(ROW_LIMIT);
  localparam int ROW_CNT_W  = 13;
  localparam int COL_CNT_W  = 11;
  localparam int CFG_DATA_W = 13;
  localparam int COST_BITS  = 16;
  localparam int SUM_BITS   = 48;
  localparam int VAL_W      = SUM_BITS + 1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  // Infinity is the single value with only the top bit set.
  localparam val_t INF_COST = {1'b1, {SUM_BITS{1'b0}}};
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_t;

  // Control for the line store chain.
  typedef struct packed {
    logic shift;
    col_t cols_m1;
  } line_ctl_t;

endpackage

// ===== rtl/core/gmpc_cell.sv =====
// One stage of the line store: holds one previous-row cost.
module gmpc_cell (
  input  logic           clk,
  input  logic           en,
  input  logic           tail,
  input  gmpc_pkg::val_t nb_d,
  input  gmpc_pkg::val_t new_d,
  output gmpc_pkg::val_t q
);

  gmpc_pkg::val_t q_r;
  gmpc_pkg::val_t q_nxt;

  // The tail stage takes the fresh cost, all others take their neighbor.
  always_comb begin
    q_nxt = tail ? new_d : nb_d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/core/gmpc_line.sv =====
// Line store as a chain of cells; after the first row, the head holds the cost above the next cell.
module gmpc_line (
  input  logic                clk,
  input  gmpc_pkg::line_ctl_t ctl,
  input  gmpc_pkg::val_t      din,
  output gmpc_pkg::val_t      head
);

  gmpc_pkg::val_t stage_q [gmpc_pkg::MAX_COLS];

  for (genvar k = 0; k < gmpc_pkg::MAX_COLS; k++) begin : g_cell
    gmpc_pkg::val_t nb;
    logic           is_tail;

    if (k == gmpc_pkg::MAX_COLS - 1) begin : g_last
      assign nb = din;
    end else begin : g_mid
      assign nb = stage_q[k+1];
    end

    assign is_tail = (ctl.cols_m1 == gmpc_pkg::col_t'(k));

    gmpc_cell u_cell (
      .clk   (clk),
      .en    (ctl.shift),
      .tail  (is_tail),
      .nb_d  (nb),
      .new_d (din),
      .q     (stage_q[k])
    );
  end

  assign head = stage_q[0];

endmodule

// ===== rtl/core/grid_min_path_cost.sv =====
// Top level: streamed grid minimum path cost with a cell-chain line store.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_cell_cost[15:0]
//   out      output     out_valid / out_stall  out_path_cost[47:0], out_reachable
//   cfg      input      cfg_valid / cfg_ready  cfg_index[0:0], cfg_data[12:0]
//
// One grid cell per cycle unless in_stall holds it; the left-neighbor add and compare is combinational.
// One result per grid, registered, valid in the cycle after the last cell is taken.
// The line store is a chain of MAX_COLS cells, tail at col_count-1, shifting once per accepted cell.
// Synchronous active-low reset clears control; a register write restarts the grid.
// in_stall rises only for a last cell while the previous result is still stalled.
module grid_min_path_cost (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gmpc_pkg::COST_BITS-1:0]      in_cell_cost,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gmpc_pkg::SUM_BITS-1:0]       out_path_cost,
  output logic                                out_reachable,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [gmpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [gmpc_pkg::ROW_CNT_W-1:0] row_count_r, row_count_nxt;
  logic [gmpc_pkg::COL_CNT_W-1:0] col_count_r, col_count_nxt;
  gmpc_pkg::col_t                 col_r, col_nxt;
  gmpc_pkg::row_t                 row_r, row_nxt;
  gmpc_pkg::val_t                 left_r, left_nxt;
  gmpc_pkg::val_t                 diag_r, diag_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [gmpc_pkg::SUM_BITS-1:0]  out_cost_r;
  logic                           out_reach_r;

  gmpc_pkg::col_t      cols_m1;
  gmpc_pkg::row_t      rows_m1;
  gmpc_pkg::val_t      up_line;
  gmpc_pkg::val_t      up;
  gmpc_pkg::val_t      best_a;
  gmpc_pkg::val_t      best;
  gmpc_pkg::val_t      cur;
  logic [gmpc_pkg::VAL_W-1:0] sum;
  gmpc_pkg::line_ctl_t line_ctl;
  logic                cfg_we;
  logic                accept;
  logic                last_col;
  logic                last_cell;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Clamp the register values into their usable range.
  always_comb begin
    if (col_count_r == '0) begin
      cols_m1 = '0;
    end else if (col_count_r > gmpc_pkg::COL_CNT_W'(gmpc_pkg::MAX_COLS)) begin
      cols_m1 = gmpc_pkg::col_t'(gmpc_pkg::MAX_COLS - 1);
    end else begin
      cols_m1 = gmpc_pkg::col_t'(col_count_r - 1'b1);
    end
    if (row_count_r == '0) begin
      rows_m1 = '0;
    end else if (row_count_r > gmpc_pkg::ROW_CNT_W'(gmpc_pkg::ROW_LIMIT)) begin
      rows_m1 = gmpc_pkg::row_t'(gmpc_pkg::ROW_LIMIT - 1);
    end else begin
      rows_m1 = gmpc_pkg::row_t'(row_count_r - 1'b1);
    end
  end

  assign last_col  = (col_r == cols_m1);
  assign last_cell = last_col && (row_r == rows_m1);
  assign in_stall  = last_cell && out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // Cell cost: least neighbor plus own cost, saturating; a zero cost or no finite neighbor gives infinity.
  always_comb begin
    up     = (row_r == '0) ? gmpc_pkg::INF_COST : up_line;
    best_a = (up < left_r) ? up : left_r;
    best   = (best_a < diag_r) ? best_a : diag_r;
    sum    = {1'b0, best[gmpc_pkg::SUM_BITS-1:0]}
           + gmpc_pkg::VAL_W'(in_cell_cost);
    if (in_cell_cost == '0 || best[gmpc_pkg::SUM_BITS]) begin
      cur = gmpc_pkg::INF_COST;
    end else if (sum[gmpc_pkg::SUM_BITS]) begin
      cur = {1'b0, gmpc_pkg::SUM_MAX};
    end else begin
      cur = sum;
    end
  end

  assign line_ctl.shift   = accept;
  assign line_ctl.cols_m1 = cols_m1;

  gmpc_line u_line (
    .clk  (clk),
    .ctl  (line_ctl),
    .din  (cur),
    .head (up_line)
  );

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_we) begin
      unique case (gmpc_pkg::cfg_reg_t'(cfg_index))
        gmpc_pkg::REG_ROW_COUNT: row_count_nxt = cfg_data;
        gmpc_pkg::REG_COL_COUNT: col_count_nxt = gmpc_pkg::COL_CNT_W'(cfg_data);
      endcase
    end
  end

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = gmpc_pkg::INF_COST;
      diag_nxt = '0;
    end else if (accept) begin
      if (!last_col) begin
        col_nxt  = col_r + 1'b1;
        left_nxt = cur;
        diag_nxt = up;
      end else if (row_r != rows_m1) begin
        col_nxt  = '0;
        row_nxt  = row_r + 1'b1;
        left_nxt = gmpc_pkg::INF_COST;
        diag_nxt = gmpc_pkg::INF_COST;
      end else begin
        // End of grid: emit and rearm at the start corner.
        col_nxt       = '0;
        row_nxt       = '0;
        left_nxt      = gmpc_pkg::INF_COST;
        diag_nxt      = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= gmpc_pkg::ROW_CNT_W'(1);
      col_count_r <= gmpc_pkg::COL_CNT_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= gmpc_pkg::INF_COST;
      diag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_cell && !cfg_we) begin
      out_cost_r  <= cur[gmpc_pkg::SUM_BITS] ? '0 : cur[gmpc_pkg::SUM_BITS-1:0];
      out_reach_r <= !cur[gmpc_pkg::SUM_BITS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_cost = out_cost_r;
  assign out_reachable = out_reach_r;

endmodule

// ===== verif/grid_min_path_cost_tb.sv =====
// Self-checking testbench for the grid minimum path cost block.
module grid_min_path_cost_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_CELLS   = 800;

  typedef struct packed {
    logic [gmpc_pkg::SUM_BITS-1:0] path_cost;
    logic                          reachable;
  } goal_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [gmpc_pkg::CFG_DATA_W-1:0] rows_w;
    logic [gmpc_pkg::CFG_DATA_W-1:0] cols_w;
    logic [gmpc_pkg::COST_BITS-1:0]  cost;
    logic                            typed;
    goal_t                           want;
  } step_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [gmpc_pkg::COST_BITS-1:0]  in_cell_cost;
  logic                            out_valid;
  logic                            out_stall;
  logic [gmpc_pkg::SUM_BITS-1:0]   out_path_cost;
  logic                            out_reachable;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [0:0]                      cfg_index;
  logic [gmpc_pkg::CFG_DATA_W-1:0] cfg_data;

  // path cost predictor state
  gmpc_pkg::val_t                  line_cost [gmpc_pkg::MAX_COLS];
  gmpc_pkg::val_t                  left_sum;
  gmpc_pkg::val_t                  diag_sum;
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [gmpc_pkg::ROW_CNT_W-1:0]  rows_reg;
  logic [gmpc_pkg::COL_CNT_W-1:0]  cols_reg;

  goal_t                 goal_q [$];
  step_t                 plan [$];
  goal_t                 seen_want;
  bit                    quiet;
  int                    mismatches;
  int                    cells_sent;
  int                    grids_checked;
  int                    cfg_writes;
  int                    idle_cycles;
  int                    stall_left;

  grid_min_path_cost u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_cost (in_cell_cost),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_path_cost(out_path_cost),
    .out_reachable(out_reachable),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned rows_used();
    return (rows_reg == 0) ? 1 :
           (rows_reg > gmpc_pkg::ROW_LIMIT) ? gmpc_pkg::ROW_LIMIT : rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    return (cols_reg == 0) ? 1 :
           (cols_reg > gmpc_pkg::MAX_COLS) ? gmpc_pkg::MAX_COLS : cols_reg;
  endfunction

  function automatic void restart_grid();
    left_sum = gmpc_pkg::INF_COST;
    diag_sum = '0;
    col_pos  = 0;
    row_pos  = 0;
  endfunction

  // Steps the predictor by one cell; returns 1 when the cell closes a grid.
  function automatic bit advance_cell(input logic [gmpc_pkg::COST_BITS-1:0] cost,
                                      output goal_t res);
    int unsigned                cols;
    int unsigned                rows;
    int unsigned                c;
    gmpc_pkg::val_t             up;
    gmpc_pkg::val_t             best;
    gmpc_pkg::val_t             cur;
    logic [gmpc_pkg::VAL_W:0]   sum;
    cols = cols_used();
    rows = rows_used();
    c    = (col_pos >= cols) ? cols - 1 : col_pos;
    up   = (row_pos == 0) ? gmpc_pkg::INF_COST : line_cost[c];
    res  = '0;
    if (cost == 0) begin
      cur = gmpc_pkg::INF_COST;
    end else begin
      best = up;
      if (left_sum < best) best = left_sum;
      if (diag_sum < best) best = diag_sum;
      if (best >= gmpc_pkg::INF_COST) begin
        cur = gmpc_pkg::INF_COST;
      end else begin
        sum = best + cost;
        cur = (sum > gmpc_pkg::SUM_MAX) ? gmpc_pkg::val_t'(gmpc_pkg::SUM_MAX)
                                        : gmpc_pkg::val_t'(sum);
      end
    end
    line_cost[c] = cur;
    left_sum     = cur;
    diag_sum     = up;
    if (c + 1 < cols) begin
      col_pos = c + 1;
      return 1'b0;
    end
    col_pos  = 0;
    left_sum = gmpc_pkg::INF_COST;
    diag_sum = gmpc_pkg::INF_COST;
    if (row_pos + 1 < rows) begin
      row_pos = row_pos + 1;
      return 1'b0;
    end
    res.reachable = (cur < gmpc_pkg::INF_COST);
    res.path_cost = res.reachable ? cur[gmpc_pkg::SUM_BITS-1:0] : '0;
    restart_grid();
    return 1'b1;
  endfunction

  function automatic logic [gmpc_pkg::COST_BITS-1:0] pick_cost(input int block_pct);
    logic [gmpc_pkg::COST_BITS-1:0] v;
    v = gmpc_pkg::COST_BITS'($urandom);
    if ($urandom_range(0, 99) < block_pct) return '0;
    case ($urandom_range(0, 3))
      0: return '1;
      1: return gmpc_pkg::COST_BITS'($urandom_range(1, 15));
      default: return (v == 0) ? gmpc_pkg::COST_BITS'(1) : v;
    endcase
  endfunction

  function automatic void add_cfg(input logic [gmpc_pkg::CFG_DATA_W-1:0] r, c);
    plan.push_back('{is_cfg: 1'b1, rows_w: r, cols_w: c, cost: '0, typed: 1'b0, want: '0});
  endfunction

  function automatic void add_cell(input logic [gmpc_pkg::COST_BITS-1:0] cost);
    plan.push_back('{is_cfg: 1'b0, rows_w: '0, cols_w: '0, cost: cost, typed: 1'b0, want: '0});
  endfunction

  function automatic void add_goal(input logic [gmpc_pkg::COST_BITS-1:0] cost,
                                   input logic [gmpc_pkg::SUM_BITS-1:0] pc, input logic r);
    plan.push_back('{is_cfg: 1'b0, rows_w: '0, cols_w: '0, cost: cost, typed: 1'b1,
                     want: '{path_cost: pc, reachable: r}});
  endfunction

  task automatic report(input string what, input logic [gmpc_pkg::SUM_BITS-1:0] got, want);
    if (mismatches < 100)
      $display("mismatch %s: got %0h want %0h at grid %0d", what, got, want, grids_checked);
    mismatches++;
  endtask

  task automatic send_cell(input logic [gmpc_pkg::COST_BITS-1:0] cost, input bit typed,
                           input goal_t want);
    goal_t got;
    int    gap;
    in_valid     <= 1'b1;
    in_cell_cost <= cost;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
    if (advance_cell(cost, got)) goal_q.push_back(typed ? want : got);
    if (cells_sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Both registers are written, only once the block has gone quiet.
  task automatic configure(input logic [gmpc_pkg::CFG_DATA_W-1:0] rows_w, cols_w);
    in_valid <= 1'b0;
    while (goal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= gmpc_pkg::REG_ROW_COUNT;
    cfg_data  <= rows_w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rows_reg = rows_w[gmpc_pkg::ROW_CNT_W-1:0];
    restart_grid();
    cfg_index <= gmpc_pkg::REG_COL_COUNT;
    cfg_data  <= cols_w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cols_reg = cols_w[gmpc_pkg::COL_CNT_W-1:0];
    restart_grid();
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  task automatic run_grids(input int grids, input int block_pct, input bit partial);
    int n;
    int cut;
    n = cols_used() * rows_used();
    repeat (grids) begin
      for (int i = 0; i < n; i++) send_cell(pick_cost(block_pct), 1'b0, '0);
    end
    // abandoned grid: the next register write restarts it
    if (partial) begin
      cut = $urandom_range(0, n - 1);
      for (int i = 0; i < cut; i++) send_cell(pick_cost(block_pct), 1'b0, '0);
    end
  endtask

  // result side: each result may be held with out_stall, drawn at random while valid
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_stall) begin
          if (out_valid) begin
            if (stall_left <= 1) out_stall <= 1'b0;
            stall_left = stall_left - 1;
          end
        end else if (out_valid) begin
          stall_left = quiet ? 0 : $urandom_range(0, 6);
          if (stall_left > 0) out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (goal_q.size() == 0) begin
        report("result with nothing pending", out_path_cost, '0);
      end else begin
        seen_want = goal_q.pop_front();
        if (out_path_cost !== seen_want.path_cost)
          report("path_cost", out_path_cost, seen_want.path_cost);
        if (out_reachable !== seen_want.reachable)
          report("reachable", gmpc_pkg::SUM_BITS'(out_reachable),
                 gmpc_pkg::SUM_BITS'(seen_want.reachable));
        grids_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_min_path_cost_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rand_cells;
    int start;
    int k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cell_cost = '0;
    cfg_valid    = 1'b0;
    cfg_index    = gmpc_pkg::REG_ROW_COUNT;
    cfg_data     = '0;
    quiet        = 1'b0;
    mismatches   = 0;
    cells_sent   = 0;
    grids_checked = 0;
    cfg_writes   = 0;
    idle_cycles  = 0;
    rand_cells   = 0;
    rows_reg     = gmpc_pkg::ROW_CNT_W'(1);
    cols_reg     = gmpc_pkg::COL_CNT_W'(1);
    foreach (line_cost[i]) line_cost[i] = '0;
    restart_grid();

    // 1x1 grids straight out of reset
    add_goal(16'd1, 48'd1, 1'b1);
    add_goal(16'hFFFF, 48'hFFFF, 1'b1);
    add_goal(16'd0, 48'd0, 1'b0);
    add_goal(16'h5A5A, 48'h5A5A, 1'b1);
    // only the diagonal step reaches the goal
    add_cfg(13'd2, 13'd2);
    add_cell(16'd3); add_cell(16'd0); add_cell(16'd0); add_cell(16'd4);
    // blocked start corner
    add_cell(16'd0); add_cell(16'd5); add_cell(16'd6); add_goal(16'd7, 48'd0, 1'b0);
    // blocked cell cuts a single row
    add_cfg(13'd1, 13'd3);
    add_cell(16'd10); add_cell(16'd0); add_cell(16'd20);
    // zero counts act as one
    add_cfg(13'd0, 13'd0);
    add_goal(16'd123, 48'd123, 1'b1);
    add_cfg(13'd3, 13'd1);
    add_cell(16'd1); add_cell(16'd2); add_cell(16'd3);
    // grid dropped partway by a register write
    add_cfg(13'd2, 13'd3);
    add_cell(16'd10); add_cell(16'd20); add_cell(16'd30); add_cell(16'd40);
    // bits above the column count width are dropped: two columns
    add_cfg(13'd1, 13'h1802);
    add_cell(16'd5); add_goal(16'd6, 48'd11, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) configure(plan[i].rows_w, plan[i].cols_w);
      else send_cell(plan[i].cost, plan[i].typed, plan[i].want);
    end

    while (rand_cells < RANDOM_CELLS) begin
      start = cells_sent;
      k = $urandom_range(0, 9);
      if (k < 7)
        configure(13'($urandom_range(0, 6)), 13'($urandom_range(0, 8)));
      else
        configure(13'($urandom_range(1, 3)), {2'($urandom), 11'($urandom_range(1, 24))});
      run_grids($urandom_range(1, 5), ($urandom_range(0, 3) == 0) ? 30 : 8,
                $urandom_range(0, 5) == 0);
      rand_cells += cells_sent - start;
    end

    in_valid <= 1'b0;
    while (goal_q.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("%0d cells streamed, %0d grid results checked, %0d register writes",
             cells_sent, grids_checked, cfg_writes);
    $display("grids from 1x1 to 6x8 and 3x24, zero and wide counts, blocked cells, "
             , "dropped grids, stalls");
    if (mismatches == 0) begin
      $display("grid_min_path_cost_tb OK");
    end else begin
      $display("grid_min_path_cost_tb NOT OK");
    end
    $finish;
  end

endmodule
